// ===== hdl/edf_task_scheduler_top_macros.svh =====
// Assertion macros shared by the scheduler controller and datapath.
// Expects clk and rst_n in the scope of each use; depends on nothing else.
`ifndef EDF_TASK_SCHEDULER_TOP_MACROS_SVH
`define EDF_TASK_SCHEDULER_TOP_MACROS_SVH
`ifndef SYNTH
// Consequent must hold in the same cycle as the antecedent
`define EDF_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Consequent must hold in the cycle after the antecedent
`define EDF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define EDF_ASSERT_SAME(label, ante, cons, msg)
`define EDF_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ===== hdl/edf_pkg.sv =====
// Package of the EDF task scheduler: sizes, opcodes, FSM states and the
// structs passed between controller and datapath. Depends on nothing.
package edf_pkg;

  // Table size and time width
  localparam int MAX_TASKS = 8;
  localparam int TIME_W    = 32;
  localparam int IDX_W     = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W     = $clog2(MAX_TASKS + 1);

  // Fixed field widths
  localparam int ACT_W  = 4;
  localparam int TIDX_W = 3;
  localparam int WORK_W = 16;
  localparam int TICK_W = 32;
  localparam int RUN_W  = 3;
  localparam int MASK_W = 8;
  localparam int BUSY_W = 32;
  localparam int MISS_W = 16;
  localparam int CMP_W  = (ACT_W > CNT_W) ? ACT_W : CNT_W;

  localparam logic [ACT_W-1:0] ACT_RESET = ACT_W'(1);

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_TICK = 1'b1
  } edf_op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_SCAN,
    S_DRAIN,
    S_FINISH
  } edf_state_t;

  typedef struct packed {
    logic              opcode;
    logic [TIDX_W-1:0] task_index;
    logic [WORK_W-1:0] arrival;
    logic [WORK_W-1:0] burst;
    logic [WORK_W-1:0] period;
  } edf_item_t;

  typedef struct packed {
    logic [TICK_W-1:0] tick_time;
    logic [RUN_W-1:0]  running_task;
    logic              cpu_idle;
    logic [MASK_W-1:0] missed_mask;
    logic [BUSY_W-1:0] busy_ticks;
    logic [MISS_W-1:0] miss_total;
  } edf_result_t;

  // Controller to datapath
  typedef struct packed {
    logic             capture;
    logic             load_wr;
    logic             scan_en;
    logic [IDX_W-1:0] scan_idx;
    logic             finish;
  } edf_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic             op_tick;
    logic [CNT_W-1:0] n_act;
    logic             out_free;
  } edf_sts_t;

endpackage

// ===== hdl/edf_in_if.sv =====
// Input channel of the EDF scheduler: valid/ready plus one item.
// Depends on edf_pkg for field widths.
interface edf_in_if;
  logic                           valid;
  logic                           ready;
  logic                           opcode;
  logic [edf_pkg::TIDX_W-1:0]     task_index;
  logic [edf_pkg::WORK_W-1:0]     arrival;
  logic [edf_pkg::WORK_W-1:0]     burst;
  logic [edf_pkg::WORK_W-1:0]     period;

  modport source (output valid, opcode, task_index, arrival, burst, period, input ready);
  modport sink   (input valid, opcode, task_index, arrival, burst, period, output ready);
endinterface

// ===== hdl/edf_out_if.sv =====
// Result channel of the EDF scheduler: valid/ready plus one tick result.
// Depends on edf_pkg for field widths.
interface edf_out_if;
  logic                         valid;
  logic                         ready;
  logic [edf_pkg::TICK_W-1:0]   tick_time;
  logic [edf_pkg::RUN_W-1:0]    running_task;
  logic                         cpu_idle;
  logic [edf_pkg::MASK_W-1:0]   missed_mask;
  logic [edf_pkg::BUSY_W-1:0]   busy_ticks;
  logic [edf_pkg::MISS_W-1:0]   miss_total;

  modport source (output valid, tick_time, running_task, cpu_idle, missed_mask,
                  busy_ticks, miss_total, input ready);
  modport sink   (input valid, tick_time, running_task, cpu_idle, missed_mask,
                  busy_ticks, miss_total, output ready);
endinterface

// ===== hdl/edf_ctrl.sv =====
// Controller FSM of the EDF scheduler: sequences load, table scan and finish.
// Depends on edf_pkg and edf_task_scheduler_top_macros.svh.
`include "edf_task_scheduler_top_macros.svh"

module edf_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  edf_pkg::edf_sts_t  sts,
  output edf_pkg::edf_cmd_t  cmd
);

  edf_pkg::edf_state_t          state_r, state_nxt;
  logic [edf_pkg::CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                         accept;

  assign accept = in_valid && in_ready;

  // Next state and scan counter
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      edf_pkg::S_IDLE: begin
        if (accept) begin
          cnt_nxt = '0;
          if (sts.op_tick) begin
            state_nxt = (sts.n_act == '0) ? edf_pkg::S_DRAIN : edf_pkg::S_SCAN;
          end else begin
            state_nxt = edf_pkg::S_LOAD;
          end
        end
      end
      edf_pkg::S_LOAD: begin
        state_nxt = edf_pkg::S_IDLE;
      end
      edf_pkg::S_SCAN: begin
        if (cnt_r == sts.n_act - edf_pkg::CNT_W'(1)) begin
          state_nxt = edf_pkg::S_DRAIN;
        end else begin
          cnt_nxt = cnt_r + edf_pkg::CNT_W'(1);
        end
      end
      edf_pkg::S_DRAIN: begin
        state_nxt = edf_pkg::S_FINISH;
      end
      edf_pkg::S_FINISH: begin
        if (sts.out_free) begin
          state_nxt = edf_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = edf_pkg::S_IDLE;
      end
    endcase
  end

  // Commands to the datapath
  always_comb begin
    in_ready     = (state_r == edf_pkg::S_IDLE);
    cmd.capture  = accept;
    cmd.load_wr  = (state_r == edf_pkg::S_LOAD);
    cmd.scan_en  = (state_r == edf_pkg::S_SCAN);
    cmd.scan_idx = cnt_r[edf_pkg::IDX_W-1:0];
    cmd.finish   = (state_r == edf_pkg::S_FINISH) && sts.out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= edf_pkg::S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  `EDF_ASSERT_SAME(a_scan_in_range, state_r == edf_pkg::S_SCAN, cnt_r < sts.n_act, "scan index past active tasks")
  `EDF_ASSERT_NEXT(a_tick_starts_scan, accept && sts.op_tick, state_r == edf_pkg::S_SCAN || state_r == edf_pkg::S_DRAIN, "tick did not start a scan")
  `EDF_ASSERT_NEXT(a_finish_to_idle, cmd.finish, state_r == edf_pkg::S_IDLE, "finish did not return to idle")

endmodule

// ===== hdl/edf_dp.sv =====
// Datapath of the EDF scheduler: task tables, release/select scan,
// counters and the result register. Depends on edf_pkg and the macro header.
`include "edf_task_scheduler_top_macros.svh"

module edf_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [edf_pkg::ACT_W-1:0]    cfg_wdata,
  input  edf_pkg::edf_item_t           in_item,
  input  edf_pkg::edf_cmd_t            cmd,
  output edf_pkg::edf_sts_t            sts,
  output logic                         out_valid,
  input  logic                         out_ready,
  output edf_pkg::edf_result_t         out_res
);

  localparam int N  = edf_pkg::MAX_TASKS;
  localparam int TW = edf_pkg::TIME_W;
  localparam int WW = edf_pkg::WORK_W;

  // Task tables
  logic [WW-1:0] burst_r  [N];
  logic [WW-1:0] period_r [N];
  logic [WW-1:0] rem_r    [N];
  logic [TW-1:0] rel_r    [N];
  logic [TW-1:0] dl_r     [N];
  logic [WW-1:0] burst_nxt  [N];
  logic [WW-1:0] period_nxt [N];
  logic [WW-1:0] rem_nxt    [N];
  logic [TW-1:0] rel_nxt    [N];
  logic [TW-1:0] dl_nxt     [N];

  logic [TW-1:0]                  time_r;
  logic [edf_pkg::BUSY_W-1:0]     busy_r;
  logic [edf_pkg::MISS_W-1:0]     miss_r, miss_nxt;
  logic [edf_pkg::ACT_W-1:0]      act_r;
  edf_pkg::edf_item_t             item_r;

  // Scan pipeline and running minimum
  logic                           pv_r;
  logic [WW-1:0]                  p_rem_r;
  logic [TW-1:0]                  p_dl_r;
  logic [edf_pkg::IDX_W-1:0]      p_idx_r;
  logic                           found_r;
  logic [TW-1:0]                  best_r;
  logic [edf_pkg::IDX_W-1:0]      sel_r;
  logic [edf_pkg::MASK_W-1:0]     mask_r;

  logic                           out_valid_r;
  edf_pkg::edf_result_t           out_res_r;

  logic [edf_pkg::IDX_W-1:0]      k;
  logic                           hit;
  logic                           miss;
  logic [TW-1:0]                  rel_sum;
  logic [WW-1:0]                  s_rem;
  logic [TW-1:0]                  s_dl;
  logic                           take;
  logic                           ld_ok;
  logic [edf_pkg::IDX_W-1:0]      ld_idx;

  // Active count clipped to the table size
  assign sts.n_act    = (edf_pkg::CMP_W'(act_r) > edf_pkg::CMP_W'(N)) ?
                        edf_pkg::CNT_W'(N) : edf_pkg::CNT_W'(act_r);
  assign sts.op_tick  = (in_item.opcode == edf_pkg::OP_TICK);
  assign sts.out_free = !out_valid_r || out_ready;

  // Release check for the scanned entry
  assign k       = cmd.scan_idx;
  assign hit     = (rel_r[k] == time_r);
  assign miss    = hit && (rem_r[k] != '0);
  assign rel_sum = rel_r[k] + TW'(period_r[k]);
  assign s_rem   = hit ? burst_r[k] : rem_r[k];
  assign s_dl    = hit ? rel_sum : dl_r[k];

  // Compare the previous entry against the running minimum
  assign take = pv_r && (p_rem_r != '0) && (!found_r || (p_dl_r < best_r));

  assign ld_ok  = int'(item_r.task_index) < N;
  assign ld_idx = edf_pkg::IDX_W'(item_r.task_index);

  // Table updates: load, scan write-back, finish decrement
  always_comb begin
    burst_nxt  = burst_r;
    period_nxt = period_r;
    rem_nxt    = rem_r;
    rel_nxt    = rel_r;
    dl_nxt     = dl_r;
    if (cmd.load_wr && ld_ok) begin
      burst_nxt[ld_idx]  = item_r.burst;
      period_nxt[ld_idx] = item_r.period;
      rem_nxt[ld_idx]    = '0;
      rel_nxt[ld_idx]    = TW'(item_r.arrival);
      dl_nxt[ld_idx]     = TW'(item_r.arrival) + TW'(item_r.period);
    end
    if (cmd.scan_en) begin
      rem_nxt[k] = s_rem;
      rel_nxt[k] = hit ? rel_sum : rel_r[k];
      dl_nxt[k]  = s_dl;
    end
    if (cmd.finish && found_r) begin
      rem_nxt[sel_r] = rem_r[sel_r] - WW'(1);
    end
  end

  // Saturating miss count
  always_comb begin
    miss_nxt = miss_r;
    if (cmd.scan_en && miss && (miss_r != '1)) begin
      miss_nxt = miss_r + edf_pkg::MISS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < N; i++) begin
        burst_r[i]  <= '0;
        period_r[i] <= '0;
        rem_r[i]    <= '0;
        rel_r[i]    <= '0;
        dl_r[i]     <= '0;
      end
      time_r      <= '0;
      busy_r      <= '0;
      miss_r      <= '0;
      act_r       <= edf_pkg::ACT_RESET;
      pv_r        <= 1'b0;
      found_r     <= 1'b0;
      mask_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      burst_r  <= burst_nxt;
      period_r <= period_nxt;
      rem_r    <= rem_nxt;
      rel_r    <= rel_nxt;
      dl_r     <= dl_nxt;
      miss_r   <= miss_nxt;
      pv_r     <= cmd.scan_en;

      if (cfg_we) begin
        act_r <= cfg_wdata;
      end

      // Clear per-tick selection on a new item
      if (cmd.capture) begin
        found_r <= 1'b0;
        mask_r  <= '0;
      end else begin
        if (take) begin
          found_r <= 1'b1;
        end
        if (cmd.scan_en && miss && (int'(k) < edf_pkg::MASK_W)) begin
          mask_r[edf_pkg::RUN_W'(k)] <= 1'b1;
        end
      end

      // Advance time and the busy count at the end of a tick
      if (cmd.finish) begin
        time_r <= time_r + TW'(1);
        if (found_r && (busy_r != '1)) begin
          busy_r <= busy_r + edf_pkg::BUSY_W'(1);
        end
      end

      // Hold the result until the transfer completes
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r <= in_item;
    end
    if (cmd.scan_en) begin
      p_rem_r <= s_rem;
      p_dl_r  <= s_dl;
      p_idx_r <= k;
    end
    if (take) begin
      best_r <= p_dl_r;
      sel_r  <= p_idx_r;
    end
    if (cmd.finish) begin
      out_res_r.tick_time    <= edf_pkg::TICK_W'(time_r);
      out_res_r.running_task <= found_r ? edf_pkg::RUN_W'(sel_r) : '0;
      out_res_r.cpu_idle     <= !found_r;
      out_res_r.missed_mask  <= mask_r;
      out_res_r.busy_ticks   <= (found_r && (busy_r != '1)) ?
                                busy_r + edf_pkg::BUSY_W'(1) : busy_r;
      out_res_r.miss_total   <= miss_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  `EDF_ASSERT_NEXT(a_pipe_follows_scan, cmd.scan_en, pv_r, "scan without compare")
  `EDF_ASSERT_SAME(a_sel_has_work, cmd.finish && found_r, rem_r[sel_r] != '0, "no work")
  `EDF_ASSERT_SAME(a_out_from_finish, $rose(out_valid_r), $past(cmd.finish), "stray result")

endmodule

// ===== hdl/edf_task_scheduler_top.sv =====
// Top level of the EDF periodic task scheduler: joins controller and datapath
// to the channel interfaces. Depends on edf_pkg, edf_in_if, edf_out_if.
//
//   channel   dir   handshake        payload
//   in_ch     in    valid/ready      opcode, task_index, arrival, burst, period
//   out_ch    out   valid/ready      tick_time .. miss_total, one per tick
//   cfg       in    cfg_we           cfg_wdata = active_tasks
//
// A load passes through the LOAD state. A tick runs SCAN over n = active tasks
// clipped to the table size (SCAN is skipped when n is 0): the scan reads one task
// entry per cycle, one compare stage drains in DRAIN, and FINISH writes the result.
// The result register holds a finished tick while the next item is accepted;
// a later tick waits in its finish cycle until that result is transferred.
// Reset (rst_n low, synchronous) clears all tables, time and counters and
// sets active_tasks to 1.
module edf_task_scheduler_top (
  input  logic                        clk,
  input  logic                        rst_n,
  edf_in_if.sink                      in_ch,
  edf_out_if.source                   out_ch,
  input  logic                        cfg_we,
  input  logic [edf_pkg::ACT_W-1:0]   cfg_wdata
);

  edf_pkg::edf_cmd_t     cmd;
  edf_pkg::edf_sts_t     sts;
  edf_pkg::edf_item_t    in_item;
  edf_pkg::edf_result_t  out_res;

  // Gather the input payload
  assign in_item.opcode     = in_ch.opcode;
  assign in_item.task_index = in_ch.task_index;
  assign in_item.arrival    = in_ch.arrival;
  assign in_item.burst      = in_ch.burst;
  assign in_item.period     = in_ch.period;

  edf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  edf_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_item   (in_item),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_res   (out_res)
  );

  // Spread the result onto the output channel
  assign out_ch.tick_time    = out_res.tick_time;
  assign out_ch.running_task = out_res.running_task;
  assign out_ch.cpu_idle     = out_res.cpu_idle;
  assign out_ch.missed_mask  = out_res.missed_mask;
  assign out_ch.busy_ticks   = out_res.busy_ticks;
  assign out_ch.miss_total   = out_res.miss_total;

endmodule
